// File: hw/rtl/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths, transaction types and controller command/status structs
// for the extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;

   localparam int DataWidth = 32;
   localparam int CntWidth  = $clog2(DataWidth);

   typedef logic [DataWidth-1:0] word_type;

   typedef struct packed {
      word_type operand_a;
      word_type operand_b;
   } egcd_req_type;

   typedef struct packed {
      word_type coef_a;
      word_type coef_b;
      word_type gcd_value;
      logic     input_invalid;
   } egcd_rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic mul_s;
      logic mul_t;
      logic update;
      logic finish;
   } egcd_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic invalid;
      logic dvs_zero;
   } egcd_sts_type;

endpackage

// File: hw/rtl/extended_gcd_bezout.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout
// Extended Euclid: gcd g and coefficients s, t with s*a + t*b = g.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_data and raise start; the transaction is taken on the edge
//   where start is high and busy is low. busy then stays high until the
//   result is produced. The result sits on rsp_data for one cycle with
//   rsp_valid high; the receiver cannot stall and must take it then.
//   Each Euclid step is one bit-serial division, two products on the
//   shared multiplier, one update and one divisor check; at most about 46
//   steps. An operand equal to the most negative value is flagged on
//   input_invalid with zero coefficients and gcd.
//   One transaction at a time: a new start can be taken in the same cycle the
//   previous result is shown.
//   Synchronous reset returns the controller to idle and drops any
//   transaction in flight; no result is produced for it.
// ----------------------------------------------------------------------------
module extended_gcd_bezout import egcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  egcd_req_type req_data,
   output logic         rsp_valid,
   output egcd_rsp_type rsp_data
);

   egcd_cmd_type cmd;
   egcd_sts_type sts;

   egcd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   egcd_datapath u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .req_data(req_data),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

   // Results never come back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // A result is shown only once the controller is idle again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // An accepted transaction makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // Flagged input returns all zeros
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.input_invalid) |->
         (rsp_data.coef_a == '0 && rsp_data.coef_b == '0 && rsp_data.gcd_value == '0))
      else $error("invalid input result not zero");

endmodule

// File: hw/rtl/egcd_div.sv
// ----------------------------------------------------------------------------
// egcd_div
// Restoring unsigned divider: one quotient bit per step, DataWidth steps.
// ----------------------------------------------------------------------------
module egcd_div import egcd_pkg::*; (
   input  logic     clock,
   input  logic     init,
   input  logic     step,
   input  word_type dividend_mag,
   input  word_type divisor_mag,
   output word_type quotient,
   output word_type remainder
);

   word_type             rem_ff, rem_in;
   word_type             quo_ff, quo_in;
   logic [DataWidth:0]   trial;

   // Shift in next dividend bit and try to subtract the divisor
   always_comb begin
      trial  = {rem_ff, quo_ff[DataWidth-1]} - {1'b0, divisor_mag};
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (init) begin
         rem_in = '0;
         quo_in = dividend_mag;
      end else if (step) begin
         if (trial[DataWidth]) begin
            rem_in = {rem_ff[DataWidth-2:0], quo_ff[DataWidth-1]};
            quo_in = {quo_ff[DataWidth-2:0], 1'b0};
         end else begin
            rem_in = trial[DataWidth-1:0];
            quo_in = {quo_ff[DataWidth-2:0], 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/egcd_datapath.sv
// ----------------------------------------------------------------------------
// egcd_datapath
// Euclid pair, Bezout coefficient registers, shared multiplier and the
// result register. Steered by the controller's command struct.
// ----------------------------------------------------------------------------
module egcd_datapath import egcd_pkg::*; (
   input  logic         clock,
   input  egcd_cmd_type cmd,
   input  egcd_req_type req_data,
   output egcd_sts_type sts,
   output egcd_rsp_type rsp_data
);

   localparam word_type MinValue = {1'b1, {(DataWidth-1){1'b0}}};
   localparam word_type OneValue = word_type'(1);

   word_type dvd_ff, dvd_in;
   word_type dvs_ff, dvs_in;
   word_type s0_ff, s0_in, s1_ff, s1_in;
   word_type t0_ff, t0_in, t1_ff, t1_in;
   word_type a_ff, a_in;
   logic     rev_ff, rev_in;
   logic     inv_ff, inv_in;
   word_type prod_ff, prod_in;
   word_type ns_ff, ns_in;
   egcd_rsp_type rsp_ff, rsp_in;

   word_type dvd_mag, dvs_mag, quo, rem, q_signed, r_signed, mul_b;
   logic [2*DataWidth-1:0] mul_full;
   word_type sa, tb;

   // Magnitudes for the unsigned divider
   assign dvd_mag = dvd_ff[DataWidth-1] ? (~dvd_ff + OneValue) : dvd_ff;
   assign dvs_mag = dvs_ff[DataWidth-1] ? (~dvs_ff + OneValue) : dvs_ff;

   egcd_div u_div (
      .clock       (clock),
      .init        (cmd.div_init),
      .step        (cmd.div_step),
      .dividend_mag(dvd_mag),
      .divisor_mag (dvs_mag),
      .quotient    (quo),
      .remainder   (rem)
   );

   // Restore truncating-division signs
   assign q_signed = (dvd_ff[DataWidth-1] ^ dvs_ff[DataWidth-1]) ? (~quo + OneValue) : quo;
   assign r_signed = dvd_ff[DataWidth-1] ? (~rem + OneValue) : rem;

   // Shared multiplier, low word only (coefficients wrap modulo 2^DataWidth)
   assign mul_b    = cmd.mul_t ? t1_ff : s1_ff;
   assign mul_full = {{DataWidth{1'b0}}, q_signed} * {{DataWidth{1'b0}}, mul_b};

   // Pick coefficients for the result, with the special cases on g = +/-a
   always_comb begin
      sa = rev_ff ? t0_ff : s0_ff;
      tb = rev_ff ? s0_ff : t0_ff;
      if (dvd_ff == a_ff) begin
         sa = OneValue;
         tb = '0;
      end
      if (dvd_ff == (~a_ff + OneValue)) begin
         sa = '1;
         tb = '0;
      end
   end

   // Next-state logic for all datapath registers
   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      a_in    = a_ff;
      rev_in  = rev_ff;
      inv_in  = inv_ff;
      prod_in = prod_ff;
      ns_in   = ns_ff;
      rsp_in  = rsp_ff;
      if (cmd.load) begin
         a_in   = req_data.operand_a;
         inv_in = (req_data.operand_a == MinValue) || (req_data.operand_b == MinValue);
         rev_in = $signed(req_data.operand_a) < $signed(req_data.operand_b);
         dvs_in = rev_in ? req_data.operand_a : req_data.operand_b;
         dvd_in = rev_in ? req_data.operand_b : req_data.operand_a;
         s0_in  = OneValue;
         s1_in  = '0;
         t0_in  = '0;
         t1_in  = OneValue;
      end
      if (cmd.mul_s || cmd.mul_t) begin
         prod_in = mul_full[DataWidth-1:0];
      end
      if (cmd.mul_t) begin
         ns_in = s0_ff - prod_ff;
      end
      if (cmd.update) begin
         s0_in  = s1_ff;
         s1_in  = ns_ff;
         t0_in  = t1_ff;
         t1_in  = t0_ff - prod_ff;
         dvd_in = dvs_ff;
         dvs_in = r_signed;
      end
      if (cmd.finish) begin
         if (inv_ff) begin
            rsp_in = '{coef_a: '0, coef_b: '0, gcd_value: '0, input_invalid: 1'b1};
         end else begin
            rsp_in = '{coef_a: sa, coef_b: tb, gcd_value: dvd_ff, input_invalid: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      s0_ff   <= s0_in;
      s1_ff   <= s1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      a_ff    <= a_in;
      rev_ff  <= rev_in;
      inv_ff  <= inv_in;
      prod_ff <= prod_in;
      ns_ff   <= ns_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.invalid  = inv_ff;
   assign sts.dvs_zero = (dvs_ff == '0);
   assign rsp_data     = rsp_ff;

endmodule

// File: hw/rtl/egcd_ctrl.sv
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer: load, then per Euclid step a full division, two multiplies
// and an update, until the divisor reaches zero.
// ----------------------------------------------------------------------------
module egcd_ctrl import egcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  egcd_sts_type sts,
   output egcd_cmd_type cmd,
   output logic         busy,
   output logic         rsp_valid
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StCheck = 3'd1;
   localparam logic [2:0] StDiv   = 3'd2;
   localparam logic [2:0] StMulS  = 3'd3;
   localparam logic [2:0] StMulT  = 3'd4;
   localparam logic [2:0] StUpd   = 3'd5;
   localparam logic [2:0] StFin   = 3'd6;

   localparam logic [CntWidth-1:0] LastStep = CntWidth'(DataWidth - 1);

   logic [2:0]          state_ff, state_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                valid_ff, valid_in;

   // Advance the sequence and issue commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (sts.invalid || sts.dvs_zero) begin
               state_in = StFin;
            end else begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LastStep) begin
               state_in = StMulS;
            end
         end
         StMulS: begin
            cmd.mul_s = 1'b1;
            state_in  = StMulT;
         end
         StMulT: begin
            cmd.mul_t = 1'b1;
            state_in  = StUpd;
         end
         StUpd: begin
            cmd.update = 1'b1;
            state_in   = StCheck;
         end
         StFin: begin
            cmd.finish = 1'b1;
            state_in   = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
      valid_in = (state_ff == StFin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != StIdle);
   assign rsp_valid = valid_ff;

endmodule

// File: tb/sv/extended_gcd_bezout_tb.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout_tb
// Self-checking bench for the extended GCD block. A queue of operand pairs
// (directed corners, then random full-range, small, common-factor,
// Fibonacci, equal, opposite and invalid pairs) feeds a clocked driver
// with random start gaps. A clocked monitor compares every result strobe
// against a Bezout predictor computed in 64-bit arithmetic on acceptance.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_tb import egcd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int       ClockPeriod = 12;
   localparam int       IdleLimit   = 10000;
   localparam int       RandomItems = 400;
   localparam word_type MostNeg     = {1'b1, {(DataWidth-1){1'b0}}};
   localparam word_type MaxPos      = ~MostNeg;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   logic         busy;
   egcd_req_type req_data = '0;
   logic         rsp_valid;
   egcd_rsp_type rsp_data;

   egcd_req_type operand_queue[$];
   egcd_rsp_type bezout_expected[$];
   int           total_items    = 0;
   int           accepted_count = 0;
   int           mismatch_count = 0;
   int           gap_left       = 0;
   int           idle_cycles    = 0;
   longint       fib[0:46];

   extended_gcd_bezout dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Gcd and coefficients by truncating Euclid over the ordered pair
   function automatic egcd_rsp_type bezout_of(egcd_req_type item);
      egcd_rsp_type res;
      longint       a, b, dvs, dvd, q, rem, s0, s1, t0, t1, ns, nt, sa, tb;
      bit           rev;
      res = '0;
      if (item.operand_a == MostNeg || item.operand_b == MostNeg) begin
         res.input_invalid = 1'b1;
         return res;
      end
      a   = $signed(item.operand_a);
      b   = $signed(item.operand_b);
      rev = (a < b);
      dvs = rev ? a : b;
      dvd = rev ? b : a;
      s0 = 1; s1 = 0; t0 = 0; t1 = 1;
      while (dvs != 0) begin
         q   = dvd / dvs;
         rem = dvd % dvs;
         ns  = s0 - q * s1;
         nt  = t0 - q * t1;
         s0  = s1;
         s1  = ns;
         t0  = t1;
         t1  = nt;
         dvd = dvs;
         dvs = rem;
      end
      sa = rev ? t0 : s0;
      tb = rev ? s0 : t0;
      // Gcd equal to a or to -a forces unit coefficients
      if (dvd == a) begin
         sa = 1;
         tb = 0;
      end
      if (dvd == -a) begin
         sa = -1;
         tb = 0;
      end
      res.coef_a    = sa[DataWidth-1:0];
      res.coef_b    = tb[DataWidth-1:0];
      res.gcd_value = dvd[DataWidth-1:0];
      return res;
   endfunction

   task automatic add_pair(word_type a, word_type b);
      egcd_req_type item;
      item.operand_a = a;
      item.operand_b = b;
      operand_queue = {operand_queue, item};
      total_items++;
   endtask

   function automatic word_type with_sign(longint mag);
      longint v;
      v = ($urandom_range(0, 1) != 0) ? -mag : mag;
      return v[DataWidth-1:0];
   endfunction

   task automatic check_field(string name, word_type exp_val, word_type act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %0d (0x%h), actual %0d (0x%h)", $time, name,
                  $signed(exp_val), exp_val, $signed(act_val), act_val);
         mismatch_count++;
      end
   endtask

   // Drive start and operands; hold start until the transaction is taken
   always @(posedge clock) begin : drive
      logic next_start;
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            bezout_expected = {bezout_expected, bezout_of(req_data)};
            accepted_count++;
            next_start = 1'b0;
            // Run bursts with no gaps now and then
            gap_left = ((accepted_count % 64) < 16) ? 0 : $urandom_range(0, 3);
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               if (!busy) gap_left = gap_left - 1;
            end else if (operand_queue.size() > 0) begin
               req_data   <= operand_queue.pop_front();
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // Compare each result strobe with the oldest expectation
   always @(posedge clock) begin : monitor
      egcd_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (bezout_expected.size() == 0) begin
            $display("%0t: unexpected result: coef_a %0d coef_b %0d gcd %0d invalid %b",
                     $time, $signed(rsp_data.coef_a), $signed(rsp_data.coef_b),
                     $signed(rsp_data.gcd_value), rsp_data.input_invalid);
            mismatch_count++;
         end else begin
            exp_rsp = bezout_expected.pop_front();
            check_field("coef_a", exp_rsp.coef_a, rsp_data.coef_a);
            check_field("coef_b", exp_rsp.coef_b, rsp_data.coef_b);
            check_field("gcd_value", exp_rsp.gcd_value, rsp_data.gcd_value);
            check_field("input_invalid", word_type'(exp_rsp.input_invalid),
                        word_type'(rsp_data.input_invalid));
         end
      end
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("%0t: timeout, %0d of %0d transactions accepted, %0d results pending",
                     $time, accepted_count, total_items, bezout_expected.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int     kind, k;
      longint g, x, y, m;
      word_type p, r;

      fib[0] = 0;
      fib[1] = 1;
      for (int i = 2; i <= 46; i++) fib[i] = fib[i-1] + fib[i-2];

      // Directed corners: zeros, invalid operand, extremes, sign mixes, worst case
      add_pair('0, '0);
      add_pair(word_type'(1), '0);
      add_pair('0, word_type'(1));
      add_pair(word_type'(-6), '0);
      add_pair('0, word_type'(-6));
      add_pair(MaxPos, '0);
      add_pair('0, MaxPos);
      add_pair(MostNeg, word_type'(5));
      add_pair(word_type'(5), MostNeg);
      add_pair(MostNeg, MostNeg);
      add_pair(MaxPos, MaxPos);
      add_pair(MaxPos, -MaxPos);
      add_pair(-MaxPos, MaxPos);
      add_pair(MaxPos, MaxPos - 1);
      add_pair(word_type'(1), word_type'(1));
      add_pair(word_type'(-1), word_type'(-1));
      add_pair(word_type'(77), word_type'(-77));
      add_pair(word_type'(12), word_type'(18));
      add_pair(word_type'(18), word_type'(12));
      add_pair(word_type'(-12), word_type'(18));
      add_pair(word_type'(12), word_type'(-18));
      add_pair(word_type'(-18), word_type'(-12));
      add_pair(word_type'(fib[46]), word_type'(fib[45]));
      add_pair(word_type'(-fib[46]), word_type'(fib[45]));
      add_pair(word_type'(fib[45]), word_type'(-fib[46]));

      // Random mix
      for (int i = 0; i < RandomItems; i++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2: begin
               add_pair($urandom, $urandom);
            end
            3, 4: begin
               add_pair(with_sign($urandom_range(0, 100)), with_sign($urandom_range(0, 100)));
            end
            5, 6: begin
               g = $urandom_range(1, 46340);
               x = $urandom_range(0, 46340);
               y = $urandom_range(0, 46340);
               add_pair(with_sign(g * x), with_sign(g * y));
            end
            7: begin
               k = $urandom_range(1, 46);
               p = with_sign(fib[k]);
               r = with_sign(fib[k-1]);
               if ($urandom_range(0, 1) != 0) add_pair(p, r);
               else add_pair(r, p);
            end
            8: begin
               // Equal or opposite operands
               m = $urandom_range(0, 32'h7fff_ffff);
               p = with_sign(m);
               add_pair(p, ($urandom_range(0, 1) != 0) ? p : -p);
            end
            default: begin
               p = ($urandom_range(0, 1) != 0) ? MostNeg : $urandom;
               r = ($urandom_range(0, 1) != 0) ? MostNeg : $urandom;
               if ($urandom_range(0, 1) != 0) add_pair(p, r);
               else add_pair(with_sign($urandom_range(0, 3)), with_sign($urandom_range(0, 3)));
            end
         endcase
      end

      // Release reset after the hold period
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Drain: all accepted, all results in, then a short quiet tail
      while (accepted_count < total_items || bezout_expected.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
